// File: rtl/core/bpc_pkg.sv
// Shared types, constants and helpers for the barometric pressure compensation block.
package bpc_pkg;

   localparam int unsigned DivSteps = 32;

   localparam logic [31:0] B6Offset = 32'd4000;
   localparam logic [31:0] PolyC1   = 32'd3038;
   localparam logic [31:0] PolyC2   = 32'hFFFF_E343; // -7357
   localparam logic [31:0] PolyC3   = 32'd3791;
   localparam logic [31:0] B7Scale  = 32'd50000;
   localparam logic [31:0] SignBit  = 32'h8000_0000;
   localparam logic [31:0] X3Bias   = 32'd32768;

   localparam logic [2:0] CsrCalA = 3'd0;
   localparam logic [2:0] CsrCalU = 3'd1;
   localparam logic [2:0] CsrCalB = 3'd2;
   localparam logic [2:0] CsrCalM = 3'd3;
   localparam logic [2:0] CsrOss  = 3'd4;

   // Divider cell payload: one restoring step per cell.
   typedef struct packed {
      logic        valid;
      logic [31:0] rem;   // partial remainder
      logic [31:0] quo;   // quotient bits shifted in, dividend bits shifted out
      logic [31:0] dvs;   // divisor magnitude
      logic        neg;   // negate the quotient at the end
      logic        zero;  // divisor was zero
   } div_cell_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
      asr32 = 32'($signed(v) >>> s);
   endfunction

endpackage

// File: rtl/core/bpc_div_cell.sv
// One restoring division step; cells chain into a pipelined divider.
module bpc_div_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  bpc_pkg::div_cell_type     cell_i,
   output bpc_pkg::div_cell_type     cell_o
);

   bpc_pkg::div_cell_type cell_ff, cell_in;
   logic [32:0] trial;
   logic [32:0] diff;

   always_comb begin
      trial   = {cell_i.rem, cell_i.quo[31]};
      diff    = trial - {1'b0, cell_i.dvs};
      cell_in = cell_i;
      cell_in.valid = cell_i.valid & ~reset;
      if (!diff[32]) begin
         cell_in.rem = diff[31:0];
         cell_in.quo = {cell_i.quo[30:0], 1'b1};
      end else begin
         cell_in.rem = trial[31:0];
         cell_in.quo = {cell_i.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule

// File: rtl/core/bpc_divider.sv
// Pipelined 32-bit signed/unsigned divider built from a row of step cells.
module bpc_divider #(
   parameter int unsigned ExtraW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [31:0]       in_num,
   input  logic [31:0]       in_den,
   input  logic              in_signed,
   input  logic [ExtraW-1:0] in_extra,
   output logic              out_valid,
   output logic [31:0]       out_quo,
   output logic              out_zero,
   output logic [ExtraW-1:0] out_extra
);

   localparam int unsigned N = bpc_pkg::DivSteps;

   bpc_pkg::div_cell_type chain [N+1];
   logic [ExtraW-1:0] extra_ff [N];
   logic nneg, dneg;

   always_comb begin
      nneg = in_signed & in_num[31];
      dneg = in_signed & in_den[31];
      chain[0].valid = in_valid;
      chain[0].rem   = '0;
      chain[0].quo   = nneg ? 32'(0 - in_num) : in_num;
      chain[0].dvs   = dneg ? 32'(0 - in_den) : in_den;
      chain[0].neg   = nneg ^ dneg;
      chain[0].zero  = (in_den == '0);
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      bpc_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_i (chain[g]),
         .cell_o (chain[g+1])
      );
      always_ff @(posedge clock) begin
         extra_ff[g] <= (g == 0) ? in_extra : extra_ff[(g == 0) ? 0 : g-1];
      end
   end

   assign out_valid = chain[N].valid;
   assign out_zero  = chain[N].zero;
   assign out_quo   = chain[N].zero ? '0 :
                      (chain[N].neg ? 32'(0 - chain[N].quo) : chain[N].quo);
   assign out_extra = extra_ff[N-1];

endmodule

// File: rtl/core/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation pipeline.
//
// Takes one raw temperature / raw pressure pair per transfer and returns the
// temperature in 0.1 C, the pressure in Pa and a divide-by-zero flag. busy is
// never raised: a new pair is taken every cycle. Each result appears on the rsp_
// ports with rsp_valid high for exactly one cycle, once the start transfer has
// passed through two 32-cell divider rows and 9 multiply and add stages;
// results leave in the order pairs came in. The receiver cannot stall. The
// calibration registers may be written only while no pair is in flight.
module barometric_pressure_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_raw_temp,
   input  logic [18:0]        req_raw_pres,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_temp_tenths,
   output logic signed [31:0] rsp_pres_pa,
   output logic               rsp_div_error,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [47:0] cal_a_ff, cal_u_ff;
   logic [31:0] cal_b_ff, cal_m_ff;
   logic [1:0]  oss_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_u_ff <= '0;
         cal_b_ff <= '0;
         cal_m_ff <= '0;
         oss_ff   <= 2'd3;
      end else if (csr_valid) begin
         case (csr_index)
            bpc_pkg::CsrCalA: cal_a_ff <= csr_wdata;
            bpc_pkg::CsrCalU: cal_u_ff <= csr_wdata;
            bpc_pkg::CsrCalB: cal_b_ff <= csr_wdata[31:0];
            bpc_pkg::CsrCalM: cal_m_ff <= csr_wdata[31:0];
            bpc_pkg::CsrOss:  oss_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = bpc_pkg::sx16(cal_a_ff[15:0]);
   assign ac2 = bpc_pkg::sx16(cal_a_ff[31:16]);
   assign ac3 = bpc_pkg::sx16(cal_a_ff[47:32]);
   assign ac4 = {16'd0, cal_u_ff[15:0]};
   assign ac5 = {16'd0, cal_u_ff[31:16]};
   assign ac6 = {16'd0, cal_u_ff[47:32]};
   assign b1  = bpc_pkg::sx16(cal_b_ff[15:0]);
   assign b2  = bpc_pkg::sx16(cal_b_ff[31:16]);
   assign mc  = bpc_pkg::sx16(cal_m_ff[15:0]);
   assign md  = bpc_pkg::sx16(cal_m_ff[31:16]);

   // ---------------- temperature: x1 ----------------
   logic        s1_v_ff;
   logic [31:0] s1_prod_ff;
   logic [18:0] s1_up_ff;
   always_ff @(posedge clock) begin
      s1_prod_ff <= 32'({16'd0, req_raw_temp} - ac6) * ac5;
      s1_up_ff   <= req_raw_pres;
      s1_v_ff    <= reset ? 1'b0 : start;
   end

   logic [31:0] s2_x1;
   assign s2_x1 = bpc_pkg::asr32(s1_prod_ff, 5'd15);

   // temperature divider: (mc << 11) / (x1 + md); carry x1 and raw_pres along
   logic        td_v, td_zero;
   logic [31:0] td_q;
   logic [50:0] td_x;
   bpc_divider #(.ExtraW(51)) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_v_ff),
      .in_num    (mc << 11),
      .in_den    (32'(s2_x1 + md)),
      .in_signed (1'b1),
      .in_extra  ({s1_up_ff, s2_x1}),
      .out_valid (td_v),
      .out_quo   (td_q),
      .out_zero  (td_zero),
      .out_extra (td_x)
   );

   // ---------------- b5, t, b6 ----------------
   logic        p1_v_ff, p1_err_ff;
   logic [31:0] p1_b6_ff;
   logic [15:0] p1_t_ff;
   logic [18:0] p1_up_ff;
   logic [31:0] b5;
   logic [31:0] t_full;
   assign b5     = 32'(td_x[31:0] + td_q);
   assign t_full = bpc_pkg::asr32(32'(b5 + 32'd8), 5'd4);
   always_ff @(posedge clock) begin
      p1_b6_ff  <= 32'(b5 - bpc_pkg::B6Offset);
      p1_t_ff   <= t_full[15:0];
      p1_up_ff  <= td_x[50:32];
      p1_err_ff <= td_zero;
      p1_v_ff   <= reset ? 1'b0 : td_v;
   end

   // products of b6
   logic        p2_v_ff, p2_err_ff;
   logic [31:0] p2_sq_ff, p2_ac2b6_ff, p2_ac3b6_ff;
   logic [15:0] p2_t_ff;
   logic [18:0] p2_up_ff;
   always_ff @(posedge clock) begin
      p2_sq_ff    <= 32'(p1_b6_ff * p1_b6_ff);
      p2_ac2b6_ff <= 32'(ac2 * p1_b6_ff);
      p2_ac3b6_ff <= 32'(ac3 * p1_b6_ff);
      p2_t_ff     <= p1_t_ff;
      p2_up_ff    <= p1_up_ff;
      p2_err_ff   <= p1_err_ff;
      p2_v_ff     <= reset ? 1'b0 : p1_v_ff;
   end

   // products of sq
   logic        p3_v_ff, p3_err_ff;
   logic [31:0] p3_b2sq_ff, p3_b1sq_ff, p3_x2a_ff, p3_x1b_ff;
   logic [15:0] p3_t_ff;
   logic [18:0] p3_up_ff;
   logic [31:0] sq;
   assign sq = bpc_pkg::asr32(p2_sq_ff, 5'd12);
   always_ff @(posedge clock) begin
      p3_b2sq_ff <= 32'(b2 * sq);
      p3_b1sq_ff <= 32'(b1 * sq);
      p3_x2a_ff  <= bpc_pkg::asr32(p2_ac2b6_ff, 5'd11);
      p3_x1b_ff  <= bpc_pkg::asr32(p2_ac3b6_ff, 5'd13);
      p3_t_ff    <= p2_t_ff;
      p3_up_ff   <= p2_up_ff;
      p3_err_ff  <= p2_err_ff;
      p3_v_ff    <= reset ? 1'b0 : p2_v_ff;
   end

   // b3 and x3 for b4
   logic        p4_v_ff, p4_err_ff;
   logic [31:0] p4_b3_ff, p4_x3_ff;
   logic [15:0] p4_t_ff;
   logic [18:0] p4_up_ff;
   logic [31:0] x3a, x3b;
   assign x3a = 32'(bpc_pkg::asr32(p3_b2sq_ff, 5'd11) + p3_x2a_ff);
   assign x3b = 32'(p3_x1b_ff + bpc_pkg::asr32(p3_b1sq_ff, 5'd16) + 32'd2);
   always_ff @(posedge clock) begin
      p4_b3_ff  <= bpc_pkg::asr32(32'((32'(ac1 * 32'd4 + x3a) << oss_ff) + 32'd2), 5'd2);
      p4_x3_ff  <= bpc_pkg::asr32(x3b, 5'd2);
      p4_t_ff   <= p3_t_ff;
      p4_up_ff  <= p3_up_ff;
      p4_err_ff <= p3_err_ff;
      p4_v_ff   <= reset ? 1'b0 : p3_v_ff;
   end

   // b4 and b7
   logic        p5_v_ff, p5_err_ff;
   logic [31:0] p5_b4_ff, p5_b7_ff;
   logic [15:0] p5_t_ff;
   always_ff @(posedge clock) begin
      p5_b4_ff  <= 32'(ac4 * 32'(p4_x3_ff + bpc_pkg::X3Bias)) >> 15;
      p5_b7_ff  <= 32'(32'({13'd0, p4_up_ff} - p4_b3_ff) * (bpc_pkg::B7Scale >> oss_ff));
      p5_t_ff   <= p4_t_ff;
      p5_err_ff <= p4_err_ff;
      p5_v_ff   <= reset ? 1'b0 : p4_v_ff;
   end

   // pressure divider (unsigned); shift placement picked by b7's top bit
   logic        pd_v, pd_zero;
   logic [31:0] pd_q;
   logic [17:0] pd_x;
   logic        b7_big;
   assign b7_big = (p5_b7_ff >= bpc_pkg::SignBit);
   bpc_divider #(.ExtraW(18)) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p5_v_ff),
      .in_num    (b7_big ? p5_b7_ff : {p5_b7_ff[30:0], 1'b0}),
      .in_den    (p5_b4_ff),
      .in_signed (1'b0),
      .in_extra  ({b7_big, p5_err_ff, p5_t_ff}),
      .out_valid (pd_v),
      .out_quo   (pd_q),
      .out_zero  (pd_zero),
      .out_extra (pd_x)
   );

   // ---------------- final polynomial ----------------
   logic        f1_v_ff, f1_err_ff;
   logic [31:0] f1_p_ff, f1_x1_ff, f1_x2_ff;
   logic [15:0] f1_t_ff;
   logic [31:0] p0, p8;
   assign p0 = pd_x[17] ? {pd_q[30:0], 1'b0} : pd_q;
   assign p8 = bpc_pkg::asr32(p0, 5'd8);
   always_ff @(posedge clock) begin
      f1_p_ff   <= p0;
      f1_x1_ff  <= 32'(p8 * p8);
      f1_x2_ff  <= 32'(bpc_pkg::PolyC2 * p0);
      f1_t_ff   <= pd_x[15:0];
      f1_err_ff <= pd_x[16] | pd_zero;
      f1_v_ff   <= reset ? 1'b0 : pd_v;
   end

   logic        f2_v_ff, f2_err_ff;
   logic [31:0] f2_p_ff, f2_x1_ff, f2_x2_ff;
   logic [15:0] f2_t_ff;
   always_ff @(posedge clock) begin
      f2_x1_ff  <= 32'(f1_x1_ff * bpc_pkg::PolyC1);
      f2_x2_ff  <= bpc_pkg::asr32(f1_x2_ff, 5'd16);
      f2_p_ff   <= f1_p_ff;
      f2_t_ff   <= f1_t_ff;
      f2_err_ff <= f1_err_ff;
      f2_v_ff   <= reset ? 1'b0 : f1_v_ff;
   end

   // output register
   logic        o_v_ff, o_err_ff;
   logic [31:0] o_p_ff;
   logic [15:0] o_t_ff;
   logic [31:0] corr;
   assign corr = bpc_pkg::asr32(
      32'(bpc_pkg::asr32(f2_x1_ff, 5'd16) + f2_x2_ff + bpc_pkg::PolyC3), 5'd4);
   always_ff @(posedge clock) begin
      o_p_ff   <= 32'(f2_p_ff + corr);
      o_t_ff   <= f2_t_ff;
      o_err_ff <= f2_err_ff;
      o_v_ff   <= reset ? 1'b0 : f2_v_ff;
   end

   assign rsp_valid       = o_v_ff;
   assign rsp_temp_tenths = o_t_ff;
   assign rsp_pres_pa     = o_p_ff;
   assign rsp_div_error   = o_err_ff;

endmodule

// File: rtl/core/bpc_checker.sv
// Port-level checks for the barometric pressure compensation block, with bind.
module bpc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);

   // start transfer to result strobe
   localparam int Latency = 73;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   a_result_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without a matching start transfer");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_ready (csr_ready)
);
